>>> sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the decimal ascii converter
// Field widths, bcd sizing, ascii codes and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    // input and output field widths
    localparam int VALUE_W  = 64;
    localparam int CHAR_W   = 8;
    localparam int LENGTH_W = 5;

    // bcd register: twenty decimal digits cover any 64-bit value
    localparam int DIGITS   = 20;
    localparam int BCD_W    = DIGITS * 4;
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_EMIT,
        ST_SPACE
    } t_state;

endpackage

`default_nettype wire

>>> sv/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned 64-bit number to decimal ascii text
// Bit-serial double dabble into bcd, then one character per ready cycle.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid / o_ready with i_value (64-bit unsigned). One item
//   is taken whenever o_ready is high, which is only while the block is idle.
//   Output channel: o_valid / i_ready with o_character, o_last, o_length.
//   Each item gives its decimal digits, most significant first and without
//   leading zeros (zero gives a single '0'), then one space with o_last set.
//   o_length carries digits plus one on every character of the run.
// Operation
//   The binary value is shifted into a 20-digit bcd register one bit per
//   cycle, then leading zero digits are dropped one per cycle, keeping at
//   least one digit, then the characters leave one per cycle while i_ready
//   is high.
// Reset and stall
//   Synchronous active-low reset returns the controller to idle and drops
//   any run in progress. A low i_ready holds the current character on the
//   output unchanged until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [bda_pkg::VALUE_W-1:0]   i_value,
    // result item
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [bda_pkg::CHAR_W-1:0]         o_character,
    output logic                               o_last,
    output logic [bda_pkg::LENGTH_W-1:0]       o_length
);

    import bda_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_W-1:0]     r_bin,   n_bin;
    logic [BCD_W-1:0]       r_bcd,   n_bcd;
    logic [BIT_CNT_W-1:0]   r_bit,   n_bit;
    logic [DIG_CNT_W-1:0]   r_ndig,  n_ndig;
    logic [DIG_CNT_W-1:0]   r_left,  n_left;

    logic [BCD_W-1:0]       adj_bcd;
    logic [3:0]             top_digit;

    // add-3 correction on every digit that is five or more
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj_bcd[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj_bcd[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_ndig <= n_ndig;
        r_left <= n_left;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bit       = r_bit;
        n_ndig      = r_ndig;
        n_left      = r_left;
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        o_last      = 1'b0;
        o_character = ASCII_SPACE;
        o_length    = LENGTH_W'(r_ndig + DIG_CNT_W'(1));

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_bin   = i_value;
                    n_bcd   = '0;
                    n_bit   = BIT_CNT_W'(VALUE_W - 1);
                    n_ndig  = DIG_CNT_W'(DIGITS);
                    n_state = ST_CONV;
                end
            end
            // one binary bit into the bcd register per cycle
            ST_CONV: begin
                n_bcd = {adj_bcd[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_bit = r_bit - BIT_CNT_W'(1);
                if (r_bit == '0) begin
                    n_state = ST_TRIM;
                end
            end
            // drop one leading zero digit per cycle, keep at least one digit
            ST_TRIM: begin
                if (top_digit == 4'd0 && r_ndig > DIG_CNT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - DIG_CNT_W'(1);
                end else begin
                    n_left  = r_ndig;
                    n_state = ST_EMIT;
                end
            end
            // digits, most significant first
            ST_EMIT: begin
                o_valid     = 1'b1;
                o_character = ASCII_ZERO + {4'd0, top_digit};
                if (i_ready) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - DIG_CNT_W'(1);
                    if (r_left == DIG_CNT_W'(1)) begin
                        n_state = ST_SPACE;
                    end
                end
            end
            // trailing space ends the run
            ST_SPACE: begin
                o_valid = 1'b1;
                o_last  = 1'b1;
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input taken while a result is pending");

    a_last_is_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_character == ASCII_SPACE))
        else $error("last character is not a space");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_length >= LENGTH_W'(2) && o_length <= LENGTH_W'(DIGITS + 1)))
        else $error("length out of range");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0 && r_left <= r_ndig))
        else $error("digit counter out of range");

    a_space_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_left == DIG_CNT_W'(1) && i_ready)
        |=> (r_state == ST_SPACE))
        else $error("space does not follow the last digit");

endmodule

`default_nettype wire
